@@ hdl/mm4_pkg.sv @@
// Shared types, constants and helpers for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DIM       = 4;
   localparam int CELLS     = DIM * DIM;
   localparam int IDX_W     = $clog2(DIM);
   localparam int CELL_W    = $clog2(CELLS);
   localparam int PIDX_W    = 4;
   localparam int PROD_W    = 64;
   localparam int SUM_W     = PROD_W + $clog2(DIM);

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DIM - 1);
   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
   localparam logic [CELL_W+PIDX_W-1:0] LAST_WIDE = (CELL_W + PIDX_W)'(CELLS - 1);
   localparam logic [PIDX_W-1:0] LAST_PIDX = LAST_WIDE[PIDX_W-1:0];

   typedef struct packed {
      logic signed [31:0] left_value;
      logic signed [31:0] right_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] product_value;
      logic [PIDX_W-1:0]  product_index;
      logic               last_of_run;
   } rsp_type;

   // one access to the operand banks: enable plus row/column of the element
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } access_type;

   // bookkeeping that travels with one product element down the pipeline
   typedef struct packed {
      logic              valid;
      logic [PIDX_W-1:0] index;
      logic              last;
   } tag_type;

   typedef enum logic [1:0] {
      ST_LOAD = 2'b01,
      ST_CALC = 2'b10
   } state_type;

   // low bits of an element position as carried on the result channel
   function automatic logic [PIDX_W-1:0] to_pidx(input logic [CELL_W-1:0] pos);
      logic [CELL_W+PIDX_W-1:0] wide;
      wide = {{PIDX_W{1'b0}}, pos};
      return wide[PIDX_W-1:0];
   endfunction

endpackage

@@ hdl/mm4_operand_store.sv @@
// Operand banks: left matrix split by column, right matrix split by row.
module mm4_operand_store (
   input  logic                             clock,
   input  logic                             advance,
   input  mm4_pkg::access_type              wr,
   input  mm4_pkg::req_type                 wr_data,
   input  mm4_pkg::access_type              rd,
   output logic [mm4_pkg::DIM-1:0][31:0]    left_ops,
   output logic [mm4_pkg::DIM-1:0][31:0]    right_ops
);

   // bank k of the left side holds left[r + DIM*k] at address r;
   // bank k of the right side holds right[k + DIM*c] at address c
   for (genvar k = 0; k < mm4_pkg::DIM; k++) begin : g_bank
      logic [31:0] left_mem  [mm4_pkg::DIM];
      logic [31:0] right_mem [mm4_pkg::DIM];
      logic [31:0] left_q_ff;
      logic [31:0] right_q_ff;

      always_ff @(posedge clock) begin
         if (wr.en && (wr.col == mm4_pkg::IDX_W'(k))) begin
            left_mem[wr.row] <= wr_data.left_value;
         end
         if (wr.en && (wr.row == mm4_pkg::IDX_W'(k))) begin
            right_mem[wr.col] <= wr_data.right_value;
         end
      end

      always_ff @(posedge clock) begin
         if (advance && rd.en) begin
            left_q_ff  <= left_mem[rd.row];
            right_q_ff <= right_mem[rd.col];
         end
      end

      assign left_ops[k]  = left_q_ff;
      assign right_ops[k] = right_q_ff;
   end

endmodule

@@ hdl/mm4_dot_unit.sv @@
// Shared dot-product unit: DIM multipliers, adder, shift and saturation.
module mm4_dot_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [mm4_pkg::DIM-1:0][31:0]    left_ops,
   input  logic [mm4_pkg::DIM-1:0][31:0]    right_ops,
   input  mm4_pkg::tag_type                 tag_in,
   output logic                             out_valid,
   output mm4_pkg::rsp_type                 out_data
);

   logic [mm4_pkg::DIM-1:0][mm4_pkg::PROD_W-1:0] prod_ff;
   logic signed [mm4_pkg::SUM_W-1:0]              sum_ff;
   logic signed [mm4_pkg::SUM_W-1:0]              sum_in;
   logic signed [mm4_pkg::SUM_W-1:0]              shifted;
   logic [mm4_pkg::SUM_W-32:0]                    upper;
   logic signed [31:0]                            sat_value;
   mm4_pkg::tag_type                              tag1_ff;
   mm4_pkg::tag_type                              tag2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < mm4_pkg::DIM; k++) begin
            prod_ff[k] <= mm4_pkg::PROD_W'($signed(left_ops[k])) *
                          mm4_pkg::PROD_W'($signed(right_ops[k]));
         end
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < mm4_pkg::DIM; k++) begin
         sum_in = sum_in + mm4_pkg::SUM_W'($signed(prod_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else if (advance) begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
      end
   end

   // arithmetic shift floors; the result fits when all bits from 31 up agree
   always_comb begin
      shifted = sum_ff >>> mm4_pkg::FRAC_BITS;
      upper   = shifted[mm4_pkg::SUM_W-1:31];
      if ((&upper) || !(|upper)) begin
         sat_value = shifted[31:0];
      end else if (shifted[mm4_pkg::SUM_W-1]) begin
         sat_value = 32'sh8000_0000;
      end else begin
         sat_value = 32'sh7fff_ffff;
      end
   end

   assign out_valid              = tag2_ff.valid;
   assign out_data.product_value = sat_value;
   assign out_data.product_index = tag2_ff.index;
   assign out_data.last_of_run   = tag2_ff.last;

endmodule

@@ hdl/matrix4_multiply_fixed.sv @@
// Top level of the 4x4 fixed-point matrix multiplier: sequencer and result register.
//
// Each req item carries one element of the left and one of the right matrix,
// column-major, signed Q16.16; a position counter places them. Items are
// accepted while the sequencer loads. After the sixteenth item the sequencer
// issues the product elements, one per cycle while the rsp channel does not
// stall, to a shared unit of four 32x32 multipliers followed by an adder and a
// shift/saturate stage. req_ready is low while the sequencer issues; loading of
// the next matrix overlaps the drain of the last elements. Results leave in
// column-major order, sums floored by the 16-bit shift and saturated to 32 bits,
// with last_of_run set on the sixteenth. A stalled rsp channel freezes the whole
// product pipeline.
module matrix4_multiply_fixed (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mm4_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mm4_pkg::rsp_type  rsp_data
);

   mm4_pkg::state_type              state_ff, state_in;
   logic [mm4_pkg::IDX_W-1:0]       row_ff, row_in;
   logic [mm4_pkg::IDX_W-1:0]       col_ff, col_in;
   logic [mm4_pkg::CELL_W-1:0]      elem_ff, elem_in;
   mm4_pkg::tag_type                tag0_ff, tag0_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   mm4_pkg::rsp_type                rsp_data_ff;

   logic                            advance;
   logic                            load;
   logic                            issue;
   logic                            wrap_row;
   mm4_pkg::access_type             wr;
   mm4_pkg::access_type             rd;
   logic [mm4_pkg::DIM-1:0][31:0]   left_ops;
   logic [mm4_pkg::DIM-1:0][31:0]   right_ops;
   logic                            dot_valid;
   mm4_pkg::rsp_type                dot_data;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == mm4_pkg::ST_LOAD);
   assign load      = req_valid && req_ready;
   assign issue     = (state_ff == mm4_pkg::ST_CALC) && advance;
   assign wrap_row  = (row_ff == mm4_pkg::LAST_IDX);

   assign wr = '{en: load, row: row_ff, col: col_ff};
   assign rd = '{en: issue, row: row_ff, col: col_ff};

   // row/col counters serve the load position and then the element position
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      elem_in  = elem_ff;
      if (load || issue) begin
         row_in = wrap_row ? '0 : row_ff + 1'b1;
         if (wrap_row) begin
            col_in = (col_ff == mm4_pkg::LAST_IDX) ? '0 : col_ff + 1'b1;
         end
         elem_in = (elem_ff == mm4_pkg::LAST_CELL) ? '0 : elem_ff + 1'b1;
      end
      unique case (state_ff)
         mm4_pkg::ST_LOAD: begin
            if (load && (elem_ff == mm4_pkg::LAST_CELL)) begin
               state_in = mm4_pkg::ST_CALC;
            end
         end
         mm4_pkg::ST_CALC: begin
            if (issue && (elem_ff == mm4_pkg::LAST_CELL)) begin
               state_in = mm4_pkg::ST_LOAD;
            end
         end
         default: state_in = mm4_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      tag0_in.valid = issue;
      tag0_in.index = mm4_pkg::to_pidx(elem_ff);
      tag0_in.last  = (elem_ff == mm4_pkg::LAST_CELL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm4_pkg::ST_LOAD;
         row_ff   <= '0;
         col_ff   <= '0;
         elem_ff  <= '0;
         tag0_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         elem_ff  <= elem_in;
         if (advance) begin
            tag0_ff <= tag0_in;
         end
      end
   end

   mm4_operand_store u_store (
      .clock     (clock),
      .advance   (advance),
      .wr        (wr),
      .wr_data   (req_data),
      .rd        (rd),
      .left_ops  (left_ops),
      .right_ops (right_ops)
   );

   mm4_dot_unit u_dot (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .left_ops  (left_ops),
      .right_ops (right_ops),
      .tag_in    (tag0_ff),
      .out_valid (dot_valid),
      .out_data  (dot_data)
   );

   assign rsp_valid_in = advance ? dot_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= dot_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/mm4_checker.sv @@
// Port-level checks for the matrix multiplier, bound to the top level.
module mm4_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mm4_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mm4_pkg::rsp_type  rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req item changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |-> rsp_data.product_index == mm4_pkg::LAST_PIDX)
      else $error("last item carries wrong index");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp item right after reset");

   a_first_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_run |=>
         !(rsp_valid && rsp_data.product_index == '0 && !rsp_data.last_of_run
           && $past(rsp_data.product_index) == mm4_pkg::LAST_PIDX))
      else $error("run restarted without last item");

endmodule

bind matrix4_multiply_fixed mm4_checker u_mm4_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
